/* rtl/scd_pkg.sv */
// Sketch command decoder package: decoded item type, kind and tool codes,
// default sizes. No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package scd_pkg;

  localparam int COORD_WIDTH_DEFAULT = 16;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // Command kinds, bits 7..6 of a command byte
  localparam logic [1:0] KIND_DX   = 2'd0;
  localparam logic [1:0] KIND_DY   = 2'd1;
  localparam logic [1:0] KIND_TOOL = 2'd2;
  localparam logic [1:0] KIND_DATA = 2'd3;

  // Classified TOOL operands
  localparam logic [3:0] TOP_NONE   = 4'd0;
  localparam logic [3:0] TOP_LINE   = 4'd1;
  localparam logic [3:0] TOP_BLOCK  = 4'd2;
  localparam logic [3:0] TOP_COLOUR = 4'd3;
  localparam logic [3:0] TOP_LOADX  = 4'd4;
  localparam logic [3:0] TOP_LOADY  = 4'd5;
  localparam logic [3:0] TOP_SHOW   = 4'd6;
  localparam logic [3:0] TOP_PAUSE  = 4'd7;
  localparam logic [3:0] TOP_FRAME  = 4'd8;
  localparam logic [3:0] TOP_OTHER  = 4'd9;

  // Current tool codes
  localparam logic [2:0] TOOL_NONE  = 3'd0;
  localparam logic [2:0] TOOL_LINE  = 3'd1;
  localparam logic [2:0] TOOL_BLOCK = 3'd2;
  localparam logic [2:0] TOOL_SHOW  = 3'd6;
  localparam logic [2:0] TOOL_PAUSE = 3'd7;

  // Result kinds
  localparam logic [2:0] OUT_LINE   = 3'd0;
  localparam logic [2:0] OUT_BLOCK  = 3'd1;
  localparam logic [2:0] OUT_COLOUR = 3'd2;
  localparam logic [2:0] OUT_SHOW   = 3'd3;
  localparam logic [2:0] OUT_PAUSE  = 3'd4;
  localparam logic [2:0] OUT_FRAME  = 3'd5;

  localparam int OPERAND_WIDTH = 6;

  typedef struct packed {
    logic                     eof;
    logic [1:0]               kind;
    logic [3:0]               tool_op;
    logic [OPERAND_WIDTH-1:0] operand;
  } dec_t;

endpackage

/* rtl/scd_front.sv */
// Front end: classifies an incoming byte or end-of-file marker into a dec_t.
// Depends on scd_pkg.
`timescale 1ns / 1ps

module scd_front
  import scd_pkg::*;
(
  input  logic       in_opcode,
  input  logic [7:0] in_command_byte,
  output dec_t       dec_o
);

  logic [3:0] tool_op;

  always_comb begin
    unique case (in_command_byte[5:0])
      6'd0:    tool_op = TOP_NONE;
      6'd1:    tool_op = TOP_LINE;
      6'd2:    tool_op = TOP_BLOCK;
      6'd3:    tool_op = TOP_COLOUR;
      6'd4:    tool_op = TOP_LOADX;
      6'd5:    tool_op = TOP_LOADY;
      6'd6:    tool_op = TOP_SHOW;
      6'd7:    tool_op = TOP_PAUSE;
      6'd8:    tool_op = TOP_FRAME;
      default: tool_op = TOP_OTHER;
    endcase
  end

  assign dec_o.eof     = in_opcode;
  assign dec_o.kind    = in_command_byte[7:6];
  assign dec_o.tool_op = tool_op;
  assign dec_o.operand = in_command_byte[5:0];

endmodule

/* rtl/scd_queue.sv */
// Short queue of decoded items between front and back end.
// Depends on scd_pkg for the item type.
`timescale 1ns / 1ps

module scd_queue
  import scd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  dec_t push_item,
  input  logic pop,
  output dec_t head_item,
  output logic not_empty,
  output logic full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dec_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  assign head_item = mem[rd_ptr_r];
  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == CNT_W'(DEPTH));

endmodule

/* rtl/scd_back.sv */
// Back end: executes decoded items against pen, target, tool and accumulator
// state and drives the registered result channel. Depends on scd_pkg.
`timescale 1ns / 1ps

module scd_back
  import scd_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  input  dec_t               item,
  output logic               item_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_cmd_kind,
  output logic signed [15:0] out_first_x,
  output logic signed [15:0] out_first_y,
  output logic signed [15:0] out_second_x,
  output logic signed [15:0] out_second_y,
  output logic [31:0]        out_payload
);

  localparam int CW = COORD_WIDTH;

  logic [CW-1:0] pen_x_r, pen_x_nxt, pen_y_r, pen_y_nxt;
  logic [CW-1:0] tgt_x_r, tgt_x_nxt, tgt_y_r, tgt_y_nxt;
  logic [2:0]    tool_r, tool_nxt;
  logic [31:0]   acc_r, acc_nxt;
  logic          frame_done_r, frame_done_nxt;

  logic          out_valid_r;
  logic [2:0]    kind_r, kind_nxt;
  logic [15:0]   fx_r, fx_nxt, fy_r, fy_nxt, sx_r, sx_nxt, sy_r, sy_nxt;
  logic [31:0]   pay_r, pay_nxt;
  logic          emit;
  logic [CW-1:0] arg_ext;

  // Zero-extend a narrow coordinate, truncate a wide one
  function automatic logic [15:0] to_out16(input logic [CW-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return w[15:0];
  endfunction

  assign arg_ext  = {{(CW - OPERAND_WIDTH){item.operand[OPERAND_WIDTH-1]}}, item.operand};
  assign item_pop = item_valid && (!out_valid_r || out_ready);

  always_comb begin
    pen_x_nxt      = pen_x_r;
    pen_y_nxt      = pen_y_r;
    tgt_x_nxt      = tgt_x_r;
    tgt_y_nxt      = tgt_y_r;
    tool_nxt       = tool_r;
    acc_nxt        = acc_r;
    frame_done_nxt = frame_done_r;
    emit           = 1'b0;
    kind_nxt       = OUT_SHOW;
    fx_nxt         = '0;
    fy_nxt         = '0;
    sx_nxt         = '0;
    sy_nxt         = '0;
    pay_nxt        = '0;

    if (item.eof) begin
      pen_x_nxt      = '0;
      pen_y_nxt      = '0;
      tgt_x_nxt      = '0;
      tgt_y_nxt      = '0;
      tool_nxt       = TOOL_LINE;
      acc_nxt        = '0;
      frame_done_nxt = 1'b0;
      emit           = 1'b1;
      kind_nxt       = OUT_SHOW;
    end else if (!frame_done_r) begin
      unique case (item.kind)
        KIND_DX: begin
          tgt_x_nxt = tgt_x_r + arg_ext;
        end
        KIND_DY: begin
          tgt_y_nxt = tgt_y_r + arg_ext;
          if (tool_r == TOOL_LINE) begin
            emit     = 1'b1;
            kind_nxt = OUT_LINE;
            fx_nxt   = to_out16(pen_x_r);
            fy_nxt   = to_out16(pen_y_r);
            sx_nxt   = to_out16(tgt_x_r);
            sy_nxt   = to_out16(tgt_y_nxt);
          end else if (tool_r == TOOL_BLOCK) begin
            emit     = 1'b1;
            kind_nxt = OUT_BLOCK;
            fx_nxt   = to_out16(pen_x_r);
            fy_nxt   = to_out16(pen_y_r);
            sx_nxt   = to_out16(tgt_x_r - pen_x_r);
            sy_nxt   = to_out16(tgt_y_nxt - pen_y_r);
          end
          pen_x_nxt = tgt_x_r;
          pen_y_nxt = tgt_y_nxt;
        end
        KIND_TOOL: begin
          unique case (item.tool_op)
            TOP_NONE:  tool_nxt = TOOL_NONE;
            TOP_LINE:  tool_nxt = TOOL_LINE;
            TOP_BLOCK: tool_nxt = TOOL_BLOCK;
            TOP_COLOUR: begin
              emit     = 1'b1;
              kind_nxt = OUT_COLOUR;
              pay_nxt  = acc_r;
            end
            TOP_LOADX: tgt_x_nxt = acc_r[CW-1:0];
            TOP_LOADY: tgt_y_nxt = acc_r[CW-1:0];
            TOP_SHOW: begin
              tool_nxt = TOOL_SHOW;
              emit     = 1'b1;
              kind_nxt = OUT_SHOW;
            end
            TOP_PAUSE: begin
              tool_nxt = TOOL_PAUSE;
              emit     = 1'b1;
              kind_nxt = OUT_PAUSE;
              pay_nxt  = acc_r;
            end
            TOP_FRAME: begin
              tool_nxt       = TOOL_NONE;
              frame_done_nxt = 1'b1;
              emit           = 1'b1;
              kind_nxt       = OUT_FRAME;
            end
            default: ;
          endcase
          acc_nxt = '0;
        end
        default: begin
          acc_nxt = {acc_r[31-OPERAND_WIDTH:0], item.operand};
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r      <= '0;
      pen_y_r      <= '0;
      tgt_x_r      <= '0;
      tgt_y_r      <= '0;
      tool_r       <= TOOL_LINE;
      acc_r        <= '0;
      frame_done_r <= 1'b0;
    end else if (item_pop) begin
      pen_x_r      <= pen_x_nxt;
      pen_y_r      <= pen_y_nxt;
      tgt_x_r      <= tgt_x_nxt;
      tgt_y_r      <= tgt_y_nxt;
      tool_r       <= tool_nxt;
      acc_r        <= acc_nxt;
      frame_done_r <= frame_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (item_pop && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop && emit) begin
      kind_r <= kind_nxt;
      fx_r   <= fx_nxt;
      fy_r   <= fy_nxt;
      sx_r   <= sx_nxt;
      sy_r   <= sy_nxt;
      pay_r  <= pay_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_cmd_kind = kind_r;
  assign out_first_x  = fx_r;
  assign out_first_y  = fy_r;
  assign out_second_x = sx_r;
  assign out_second_y = sy_r;
  assign out_payload  = pay_r;

endmodule

/* rtl/sketch_command_decoder.sv */
// Top level of the sketch command decoder: front end, item queue, back end.
// Depends on scd_pkg, scd_front, scd_queue and scd_back.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-----------------------------------
//  in_      | input     | in_valid/in_ready   | opcode, command_byte
//  out_     | output    | out_valid/out_ready | cmd_kind, first/second x/y, payload
//
// One transaction per cycle sustained while the output is not stalled: the back
// end executes one queued item per cycle and its state update is one coordinate
// add, so the input accepts a byte every cycle while the queue has room.
// A result is offered once its input transaction has been written into the
// queue and the queued item has executed into the result register.
// Reset is synchronous; no clearing pass is needed.
// A stalled output holds the back end; the queue absorbs up to QUEUE_DEPTH
// transactions before in_ready drops.
`timescale 1ns / 1ps

module sketch_command_decoder
  import scd_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_opcode,
  input  logic [7:0]         in_command_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_cmd_kind,
  output logic signed [15:0] out_first_x,
  output logic signed [15:0] out_first_y,
  output logic signed [15:0] out_second_x,
  output logic signed [15:0] out_second_y,
  output logic [31:0]        out_payload
);

  dec_t front_item;
  dec_t head_item;
  logic q_full;
  logic q_not_empty;
  logic q_pop;

  // Classify the byte as it arrives
  scd_front u_front (
    .in_opcode       (in_opcode),
    .in_command_byte (in_command_byte),
    .dec_o           (front_item)
  );

  // Accept whenever the queue has room, independent of the result side
  assign in_ready = !q_full;

  scd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid && in_ready),
    .push_item (front_item),
    .pop       (q_pop),
    .head_item (head_item),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  // Execute queued items; advance only when the result register can take one
  scd_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (q_not_empty),
    .item         (head_item),
    .item_pop     (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_cmd_kind (out_cmd_kind),
    .out_first_x  (out_first_x),
    .out_first_y  (out_first_y),
    .out_second_x (out_second_x),
    .out_second_y (out_second_y),
    .out_payload  (out_payload)
  );

endmodule

/* rtl/scd_checker.sv */
// Port-level checks for sketch_command_decoder, attached by bind.
// Depends on scd_pkg for result kind codes.
`timescale 1ns / 1ps

module scd_checker
  import scd_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_opcode,
  input logic [7:0]         in_command_byte,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         out_cmd_kind,
  input logic signed [15:0] out_first_x,
  input logic signed [15:0] out_first_y,
  input logic signed [15:0] out_second_x,
  input logic signed [15:0] out_second_y,
  input logic [31:0]        out_payload
);

  // A cycle in reset leaves no result pending
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Hold a waiting input transaction
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_opcode) && $stable(in_command_byte))
    else $error("waiting input changed");

  // Hold a stalled result: valid, kind, payload, first x and second y
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cmd_kind)
      && $stable(out_payload) && $stable(out_first_x) && $stable(out_second_y))
    else $error("stalled result changed");

  // Non-drawing results carry zero coordinates
  a_coords_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cmd_kind != OUT_LINE && out_cmd_kind != OUT_BLOCK
      |-> out_first_x == 0 && out_first_y == 0 && out_second_x == 0 && out_second_y == 0)
    else $error("coordinates set on non-drawing result");

  // Only colour and pause carry the accumulator
  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cmd_kind != OUT_COLOUR && out_cmd_kind != OUT_PAUSE
      |-> out_payload == 0)
    else $error("payload set on result without one");

endmodule

bind sketch_command_decoder scd_checker u_scd_checker (.*);

/* tb/tb.sv */
// Self-checking testbench for sketch_command_decoder: directed and random byte streams.
// Depends on scd_pkg and the sketch_command_decoder RTL. A scoreboard class holds
// an inline decoder model, predicts each result and compares it with the DUT.
`timescale 1ns / 1ps

module tb;
  import scd_pkg::*;

  // Drop out if this many cycles pass with no transaction on either channel
  localparam int STALL_LIMIT = 2000;
  // Cycles to hold after the last expected result for any stray output
  localparam int TAIL_CYCLES = 24;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] first_x;
    logic [15:0] first_y;
    logic [15:0] second_x;
    logic [15:0] second_y;
    logic [31:0] payload;
  } sketch_cmd_t;

  // Scoreboard: tracks decoder state, queues predicted commands and checks
  // each DUT result against the oldest prediction.
  class sketch_scoreboard;
    logic [15:0]  pen_x, pen_y, target_x, target_y;
    logic [2:0]   tool;
    logic [31:0]  acc;
    bit           frame_closed;
    sketch_cmd_t  pending_cmds[$];
    int           errors;
    int           bytes_seen;
    int           cmds_seen;
    int           kind_hits[6];

    function void clear_state();
      pen_x = '0;
      pen_y = '0;
      target_x = '0;
      target_y = '0;
      tool = TOOL_LINE;
      acc = '0;
      frame_closed = 1'b0;
    endfunction

    function int pending();
      return pending_cmds.size();
    endfunction

    task report(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    function void push_cmd(input logic [2:0] kind, input logic [15:0] fx, input logic [15:0] fy,
                           input logic [15:0] sx, input logic [15:0] sy,
                           input logic [31:0] pay);
      sketch_cmd_t c;
      c.kind = kind;
      c.first_x = fx;
      c.first_y = fy;
      c.second_x = sx;
      c.second_y = sy;
      c.payload = pay;
      pending_cmds.push_back(c);
    endfunction

    // Advance the decoder state by one accepted input transaction
    function void note_transaction(input logic eof, input logic [7:0] cmd_byte);
      logic [1:0]  kind;
      logic [5:0]  operand;
      logic [15:0] delta;
      logic [3:0]  tool_op;
      kind = cmd_byte[7:6];
      operand = cmd_byte[5:0];
      delta = {{10{operand[5]}}, operand};
      bytes_seen++;
      if (eof) begin
        clear_state();
        push_cmd(OUT_SHOW, '0, '0, '0, '0, '0);
        return;
      end
      // Everything after a frame end is dropped until end of file
      if (frame_closed) return;
      case (kind)
        KIND_DX: target_x = target_x + delta;
        KIND_DY: begin
          target_y = target_y + delta;
          if (tool == TOOL_LINE)
            push_cmd(OUT_LINE, pen_x, pen_y, target_x, target_y, '0);
          else if (tool == TOOL_BLOCK)
            push_cmd(OUT_BLOCK, pen_x, pen_y, target_x - pen_x, target_y - pen_y, '0);
          pen_x = target_x;
          pen_y = target_y;
        end
        KIND_TOOL: begin
          // Negative operands and anything above frame end are unknown tools
          if (operand[5:4] == 2'b00 && operand[3:0] <= TOP_FRAME) tool_op = operand[3:0];
          else tool_op = TOP_OTHER;
          case (tool_op)
            TOP_NONE:   tool = TOOL_NONE;
            TOP_LINE:   tool = TOOL_LINE;
            TOP_BLOCK:  tool = TOOL_BLOCK;
            TOP_COLOUR: push_cmd(OUT_COLOUR, '0, '0, '0, '0, acc);
            TOP_LOADX:  target_x = acc[15:0];
            TOP_LOADY:  target_y = acc[15:0];
            TOP_SHOW: begin
              tool = TOOL_SHOW;
              push_cmd(OUT_SHOW, '0, '0, '0, '0, '0);
            end
            TOP_PAUSE: begin
              tool = TOOL_PAUSE;
              push_cmd(OUT_PAUSE, '0, '0, '0, '0, acc);
            end
            TOP_FRAME: begin
              tool = TOOL_NONE;
              frame_closed = 1'b1;
              push_cmd(OUT_FRAME, '0, '0, '0, '0, '0);
            end
            default: ;
          endcase
          acc = '0;
        end
        default: acc = {acc[25:0], operand};
      endcase
    endfunction

    task check_result(input sketch_cmd_t got);
      sketch_cmd_t want;
      cmds_seen++;
      if (pending_cmds.size() == 0) begin
        report($sformatf("unexpected result kind %0d", got.kind));
        return;
      end
      want = pending_cmds.pop_front();
      if (want.kind < 6) kind_hits[want.kind]++;
      if (got.kind !== want.kind)
        report($sformatf("cmd_kind got %0d want %0d", got.kind, want.kind));
      if (got.first_x !== want.first_x)
        report($sformatf("first_x got %h want %h", got.first_x, want.first_x));
      if (got.first_y !== want.first_y)
        report($sformatf("first_y got %h want %h", got.first_y, want.first_y));
      if (got.second_x !== want.second_x)
        report($sformatf("second_x got %h want %h", got.second_x, want.second_x));
      if (got.second_y !== want.second_y)
        report($sformatf("second_y got %h want %h", got.second_y, want.second_y));
      if (got.payload !== want.payload)
        report($sformatf("payload got %h want %h", got.payload, want.payload));
    endtask
  endclass

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_opcode = 1'b0;
  logic [7:0]         in_command_byte = 8'h00;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         out_cmd_kind;
  logic signed [15:0] out_first_x;
  logic signed [15:0] out_first_y;
  logic signed [15:0] out_second_x;
  logic signed [15:0] out_second_y;
  logic [31:0]        out_payload;

  // Random idling on each side; cleared for the quiet stretch
  bit                 sender_gaps = 1'b0;
  bit                 receiver_stalls = 1'b0;
  int                 quiet_cycles = 0;
  sketch_scoreboard   sb;

  sketch_command_decoder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_command_byte (in_command_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_cmd_kind    (out_cmd_kind),
    .out_first_x     (out_first_x),
    .out_first_y     (out_first_y),
    .out_second_x    (out_second_x),
    .out_second_y    (out_second_y),
    .out_payload     (out_payload)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: drop ready on a random draw, 14 in 100 odds, while stalls are enabled
  always @(negedge clk) begin
    out_ready <= (receiver_stalls && $urandom_range(99) < 14) ? 1'b0 : 1'b1;
  end

  // Monitor: sample both channels at the rising edge, feed the scoreboard,
  // and run the watchdog on cycles with no transaction at all.
  always @(posedge clk) begin : monitor_blk
    bit moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_transaction(in_opcode, in_command_byte);
        moved = 1'b1;
      end
      if (out_valid && out_ready) begin
        sb.check_result({out_cmd_kind, out_first_x, out_first_y, out_second_x, out_second_y,
                         out_payload});
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, sb.pending());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Present one input transaction, starting and ending at a falling edge.
  // Idle gaps drop valid before the byte goes out; once up, valid holds.
  task automatic send_byte(input logic eof, input logic [7:0] cmd_byte);
    while (sender_gaps && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= eof;
    in_command_byte <= cmd_byte;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold the sender off until every predicted command has come out
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Directed stream: operand extremes, every tool code, line and block draws,
  // accumulator overflow, target load truncation and wrap, unknown tools,
  // draws with no tool, bytes dropped after frame end, end of file.
  task automatic directed_stream();
    send_byte(1'b1, 8'h00);               // end of file straight out of reset
    send_byte(1'b0, {KIND_DX, 6'h1f});    // dx +31
    send_byte(1'b0, {KIND_DX, 6'h20});    // dx -32
    send_byte(1'b0, {KIND_DY, 6'h1f});    // dy +31, line
    send_byte(1'b0, {KIND_DY, 6'h20});    // dy -32, line
    send_byte(1'b0, {KIND_TOOL, 6'(TOP_BLOCK)});
    send_byte(1'b0, {KIND_DY, 6'h01});    // block
    repeat (6) send_byte(1'b0, {KIND_DATA, 6'h3f});   // 36 bits, top ones lost
    send_byte(1'b0, {KIND_TOOL, 6'(TOP_COLOUR)});
    repeat (3) send_byte(1'b0, {KIND_DATA, 6'h3f});   // 18 bits into a 16-bit target
    send_byte(1'b0, {KIND_TOOL, 6'(TOP_LOADX)});
    send_byte(1'b0, {KIND_DX, 6'h01});    // wrap 0xffff -> 0
    send_byte(1'b0, {KIND_TOOL, 6'(TOP_LOADY)});
    send_byte(1'b0, {KIND_TOOL, 6'(TOP_NONE)});
    send_byte(1'b0, {KIND_DY, 6'h05});    // no tool, no draw
    send_byte(1'b0, {KIND_TOOL, 6'(TOP_LINE)});
    send_byte(1'b0, {KIND_DATA, 6'h05});
    send_byte(1'b0, {KIND_TOOL, 6'(TOP_PAUSE)});
    send_byte(1'b0, {KIND_DY, 6'h01});    // pause tool draws nothing
    send_byte(1'b0, {KIND_TOOL, 6'(TOP_SHOW)});
    send_byte(1'b0, {KIND_TOOL, 6'h3f});  // unknown, negative
    send_byte(1'b0, {KIND_TOOL, 6'h09});  // unknown, just above frame end
    send_byte(1'b0, {KIND_TOOL, 6'(TOP_FRAME)});
    send_byte(1'b0, {KIND_DY, 6'h1f});    // dropped after frame end
    send_byte(1'b1, 8'hff);               // end of file, byte ignored
  endtask

  // Random sketches: mostly well-formed drawing with random operands, tool
  // codes biased to the known ones, with frame ends followed by a few dropped
  // bytes and end of file. Dropped bytes do not count toward the total.
  task automatic random_sketches(input int count);
    int         sent;
    int         pick;
    logic [5:0] arg;
    bit         closed;
    sent = 0;
    closed = 1'b0;
    while (sent < count) begin
      if (closed) begin
        repeat ($urandom_range(4)) send_byte(1'b0, 8'($urandom));
        send_byte(1'b1, 8'($urandom));
        closed = 1'b0;
      end else begin
        pick = $urandom_range(99);
        if (pick < 3) begin
          send_byte(1'b1, 8'($urandom));
        end else if (pick < 26) begin
          send_byte(1'b0, {KIND_DX, 6'($urandom)});
        end else if (pick < 50) begin
          send_byte(1'b0, {KIND_DY, 6'($urandom)});
        end else if (pick < 70) begin
          send_byte(1'b0, {KIND_DATA, 6'($urandom)});
        end else begin
          pick = $urandom_range(99);
          if (pick < 84) arg = 6'($urandom_range(7));
          else if (pick < 92) arg = 6'(TOP_FRAME);
          else arg = 6'($urandom);
          if (arg == 6'(TOP_FRAME)) closed = 1'b1;
          send_byte(1'b0, {KIND_TOOL, arg});
        end
      end
      sent++;
    end
  endtask

  initial begin
    sb = new;
    sb.clear_state();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    directed_stream();
    drain();

    sender_gaps = 1'b1;
    receiver_stalls = 1'b1;
    random_sketches(600);
    drain();

    // Quiet stretch: back-to-back traffic on both sides
    sender_gaps = 1'b0;
    receiver_stalls = 1'b0;
    random_sketches(450);

    sender_gaps = 1'b1;
    receiver_stalls = 1'b1;
    random_sketches(800);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d input transactions and checked %0d commands", sb.bytes_seen,
             sb.cmds_seen);
    $display("lines %0d, blocks %0d, colours %0d, shows %0d, pauses %0d, frame ends %0d",
             sb.kind_hits[OUT_LINE], sb.kind_hits[OUT_BLOCK], sb.kind_hits[OUT_COLOUR],
             sb.kind_hits[OUT_SHOW], sb.kind_hits[OUT_PAUSE], sb.kind_hits[OUT_FRAME]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
